/* rtl/biquad_iir_filter_macros.svh */
// Assertion helpers shared by the filter RTL.
// Each macro samples on clk and is held off while rst is high.
`ifndef BIQUAD_IIR_FILTER_MACROS_SVH
`define BIQUAD_IIR_FILTER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define BQF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define BQF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bqf_pkg.sv */
package bqf_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 32;
  localparam int OUT_W     = 24;
  localparam int FRAC_W    = 30;                    // Q2.30 coefficient fraction
  localparam int FF_SHIFT  = 8;                     // integer input to Q.8 scale
  localparam int FF_PROD_W = COEF_W + SAMPLE_W;     // 48
  localparam int FB_PROD_W = COEF_W + OUT_W;        // 56
  localparam int FF_SUM_W  = FF_PROD_W + 2;         // three terms
  localparam int FB_SUM_W  = FB_PROD_W + 1;         // two terms
  localparam int ACC_W     = 60;                    // exact sum fits below 2^58
  localparam int Q_W       = ACC_W - FRAC_W;        // 30
  localparam int CFG_IDX_W = 3;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);
  localparam logic signed [OUT_W-1:0] OUT_MAX    = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN    = {1'b1, {(OUT_W-1){1'b0}}};

  // Coefficient reset values: band-pass set
  localparam logic signed [COEF_W-1:0] B0_RESET = 32'sd1013427;
  localparam logic signed [COEF_W-1:0] B1_RESET = 32'sd0;
  localparam logic signed [COEF_W-1:0] B2_RESET = -32'sd1013427;
  localparam logic signed [COEF_W-1:0] A1_RESET = -32'sd2145414446;
  localparam logic signed [COEF_W-1:0] A2_RESET = 32'sd1071714971;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEED_COEF_0 = 3'd0,
    CFG_FEED_COEF_1 = 3'd1,
    CFG_FEED_COEF_2 = 3'd2,
    CFG_BACK_COEF_1 = 3'd3,
    CFG_BACK_COEF_2 = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_set_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [OUT_W-1:0]    y1;
    logic signed [OUT_W-1:0]    y2;
  } delay_line_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] y;
    logic                    sat;
  } result_t;

endpackage

/* rtl/bqf_datapath.sv */
module bqf_datapath
  import bqf_pkg::*;
(
  input  logic signed [SAMPLE_W-1:0] sample,
  input  coef_set_t                  coef,
  input  delay_line_t                dly,
  output result_t                    result
);

  logic signed [FF_PROD_W-1:0] p_b0, p_b1, p_b2;
  logic signed [FB_PROD_W-1:0] p_a1, p_a2;
  logic signed [FF_SUM_W-1:0]  ff_sum;
  logic signed [FB_SUM_W-1:0]  fb_sum;
  logic signed [ACC_W-1:0]     acc;
  logic signed [Q_W-1:0]       q;
  logic                        pos_over, neg_over;

  // Five independent products
  assign p_b0 = coef.b0 * sample;
  assign p_b1 = coef.b1 * dly.x1;
  assign p_b2 = coef.b2 * dly.x2;
  assign p_a1 = coef.a1 * dly.y1;
  assign p_a2 = coef.a2 * dly.y2;

  // Feed-forward and feedback sums at full precision
  assign ff_sum = FF_SUM_W'(p_b0) + FF_SUM_W'(p_b1) + FF_SUM_W'(p_b2);
  assign fb_sum = FB_SUM_W'(p_a1) + FB_SUM_W'(p_a2);

  // Align feed-forward to the 2^-38 scale, subtract feedback, add half LSB
  assign acc = (ACC_W'(ff_sum) <<< FF_SHIFT) - ACC_W'(fb_sum) + ROUND_HALF;

  // Floor shift by 2^30 is a plain bit select of the two's complement sum
  assign q = acc[ACC_W-1:FRAC_W];

  // Out of range when the bits above the output sign disagree with it
  assign pos_over = !q[Q_W-1] && (|q[Q_W-2:OUT_W-1]);
  assign neg_over =  q[Q_W-1] && !(&q[Q_W-2:OUT_W-1]);

  always_comb begin
    result.sat = pos_over || neg_over;
    if (pos_over) begin
      result.y = OUT_MAX;
    end else if (neg_over) begin
      result.y = OUT_MIN;
    end else begin
      result.y = q[OUT_W-1:0];
    end
  end

endmodule

/* rtl/biquad_iir_filter.sv */
// Second-order direct-form-I IIR filter (biquad), fixed point.
// Input stream: one signed 16-bit sample per transfer on s_axis.
// Output stream: one Q16.8 result per sample on m_axis; m_axis_tuser
// is high when the rounded sum had to be clipped to 24 bits.
// Coefficients b0, b1, b2, a1, a2 are signed Q2.30, written through
// cfg_we / cfg_index / cfg_data (indexes 0..4, others ignored). Write
// them only while no sample is in flight.
// A sample taken into the input register moves on into the result register,
// which presents it on m_axis. Throughput: one sample per cycle while m_axis
// does not stall, set by the loop from the output delays through the datapath
// back into them (five multiplies and one wide sum between the two registers).
// A new sample is taken whenever the input register is empty or moves on
// in the same cycle; it moves on when the result register is empty or
// being taken. When m_axis stalls, one result and one sample are held and
// s_axis_tready drops.
// Reset clears both stages and all delays, and loads the band-pass
// coefficient set.
module biquad_iir_filter
  import bqf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Config write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  // Sample input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // [15:0] sample_in
  // Filter output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,   // [23:0] filtered_out
  output logic                 m_axis_tuser    // [0] saturated
);

`include "biquad_iir_filter_macros.svh"

  coef_set_t                  coef;
  delay_line_t                dly;
  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic                       out_valid;
  result_t                    out_result;
  result_t                    dp_result;
  logic                       fire;

  // Stage advance: result register free or being drained
  assign fire          = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || fire;

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0 <= B0_RESET;
      coef.b1 <= B1_RESET;
      coef.b2 <= B2_RESET;
      coef.a1 <= A1_RESET;
      coef.a2 <= A2_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_FEED_COEF_0: coef.b0 <= cfg_data;
        CFG_FEED_COEF_1: coef.b1 <= cfg_data;
        CFG_FEED_COEF_2: coef.b2 <= cfg_data;
        CFG_BACK_COEF_1: coef.a1 <= cfg_data;
        CFG_BACK_COEF_2: coef.a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_sample <= s_axis_tdata;
    end
  end

  bqf_datapath u_datapath (
    .sample (s1_sample),
    .coef   (coef),
    .dly    (dly),
    .result (dp_result)
  );

  // Delay line advances with each computed sample
  always_ff @(posedge clk) begin
    if (rst) begin
      dly <= '0;
    end else if (fire) begin
      dly.x2 <= dly.x1;
      dly.x1 <= s1_sample;
      dly.y2 <= dly.y1;
      dly.y1 <= dp_result.y;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= dp_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_result.y;
  assign m_axis_tuser  = out_result.sat;

  // Checks
  `BQF_ASSERT_SAME(a_sat_is_clamped,
    m_axis_tvalid && m_axis_tuser,
    (m_axis_tdata == OUT_MAX) || (m_axis_tdata == OUT_MIN),
    "saturated result is not at a rail")
  `BQF_ASSERT_NEXT(a_fire_loads_output, fire, m_axis_tvalid,
    "computed result did not reach the output register")
  `BQF_ASSERT_NEXT(a_feedback_matches_output, fire, dly.y1 == out_result.y,
    "feedback delay differs from the delivered result")
  `BQF_ASSERT_SAME(a_no_overrun, s1_valid && !fire, !s_axis_tready,
    "input register would be overwritten while held")

endmodule
